// ===== src/tsu_pkg.sv =====
// -----------------------------------------------------------------------------
// tsu_pkg: shared definitions for the token scanner
// Token kinds, widths, byte classes and the keyword patterns.
// -----------------------------------------------------------------------------
package tsu_pkg;

	localparam int OFFSET_BITS_DEF   = 24;
	localparam int POSITION_BITS_DEF = 16;
	localparam int LEN_BITS          = 16;
	localparam int KIND_BITS         = 5;
	localparam int PREFIX_BITS       = 40;
	localparam int QDEPTH            = 4;

	typedef logic [KIND_BITS-1:0] kind_t;

	localparam kind_t K_PLUS   = 5'd0;
	localparam kind_t K_MINUS  = 5'd1;
	localparam kind_t K_STAR   = 5'd2;
	localparam kind_t K_SLASH  = 5'd3;
	localparam kind_t K_SEMI   = 5'd4;
	localparam kind_t K_EQ     = 5'd5;
	localparam kind_t K_LPAREN = 5'd6;
	localparam kind_t K_RPAREN = 5'd7;
	localparam kind_t K_COMMA  = 5'd8;
	localparam kind_t K_ASSIGN = 5'd9;
	localparam kind_t K_COLON  = 5'd10;
	localparam kind_t K_LBRACE = 5'd11;
	localparam kind_t K_RBRACE = 5'd12;
	localparam kind_t K_INT    = 5'd13;
	localparam kind_t K_IDENT  = 5'd14;
	localparam kind_t K_LET    = 5'd15;
	localparam kind_t K_ELIF   = 5'd16;
	localparam kind_t K_IF     = 5'd17;
	localparam kind_t K_ELSE   = 5'd18;
	localparam kind_t K_WHILE  = 5'd19;
	localparam kind_t K_EOF    = 5'd20;
	localparam kind_t K_ERROR  = 5'd21;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;

	localparam logic [PREFIX_BITS-1:0] KW_IF    = 40'h00_0000_6966;
	localparam logic [PREFIX_BITS-1:0] KW_LET   = 40'h00_006C_6574;
	localparam logic [PREFIX_BITS-1:0] KW_ELIF  = 40'h00_656C_6966;
	localparam logic [PREFIX_BITS-1:0] KW_ELSE  = 40'h00_656C_7365;
	localparam logic [PREFIX_BITS-1:0] KW_WHILE = 40'h77_6869_6C65;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_DIGITS = 4'b0010,
		MODE_WORD   = 4'b0100,
		MODE_COLON  = 4'b1000
	} mode_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_word_start(input logic [7:0] b);
		return b inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b inside {8'h20, [8'h09:8'h0D]};
	endfunction

	// {hit, kind} for the single-character operators and brackets
	function automatic logic [KIND_BITS:0] punct_kind(input logic [7:0] b);
		logic [KIND_BITS:0] r;
		case (b)
			8'h2B: r = {1'b1, K_PLUS};
			8'h2D: r = {1'b1, K_MINUS};
			8'h2A: r = {1'b1, K_STAR};
			8'h2F: r = {1'b1, K_SLASH};
			8'h3B: r = {1'b1, K_SEMI};
			8'h3D: r = {1'b1, K_EQ};
			8'h28: r = {1'b1, K_LPAREN};
			8'h29: r = {1'b1, K_RPAREN};
			8'h2C: r = {1'b1, K_COMMA};
			8'h7B: r = {1'b1, K_LBRACE};
			8'h7D: r = {1'b1, K_RBRACE};
			default: r = {1'b0, K_PLUS};
		endcase
		return r;
	endfunction

	function automatic kind_t word_kind(input logic [LEN_BITS-1:0] len,
		input logic [PREFIX_BITS-1:0] pfx);
		kind_t k;
		k = K_IDENT;
		if (len == LEN_BITS'(2) && pfx == KW_IF) k = K_IF;
		else if (len == LEN_BITS'(3) && pfx == KW_LET) k = K_LET;
		else if (len == LEN_BITS'(4) && pfx == KW_ELIF) k = K_ELIF;
		else if (len == LEN_BITS'(4) && pfx == KW_ELSE) k = K_ELSE;
		else if (len == LEN_BITS'(5) && pfx == KW_WHILE) k = K_WHILE;
		return k;
	endfunction

endpackage

// ===== src/token_scanner_unit.sv =====
// -----------------------------------------------------------------------------
// token_scanner_unit: streaming lexer, one source byte per item
// Classifies each byte against the running scan state and queues tokens.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel text_valid/text_ready carries text_byte and is_end. A zero
//   byte or is_end flushes any pending token and yields an EOF token; scanning
//   may continue afterwards with the counters as they stand.
//   Output channel token_valid/token_ready carries one token per item: kind,
//   start offset, length, line, column and last_of_run, which marks the last
//   token caused by one input byte (a byte can cause zero, one or two).
// Throughput: one byte per cycle while text_ready is high. The scan state is
//   updated in the cycle of acceptance; results go into a 4-entry output
//   queue, and a byte is taken only while two slots are free, so a byte that
//   gives two tokens always fits. A token is offered from the queue once the
//   byte that completes it has been accepted.
// Stall: while token_ready is low the head token holds; once the queue has
//   fewer than two free slots text_ready drops. Nothing is ever dropped.
// Reset (arst_n low): scan state idle, offset 0, line and column 1, queue
//   empty. No clearing pass is needed.
// -----------------------------------------------------------------------------
module token_scanner_unit #(
	parameter int OFFSET_BITS   = tsu_pkg::OFFSET_BITS_DEF,
	parameter int POSITION_BITS = tsu_pkg::POSITION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          text_valid,
	output logic                          text_ready,
	input  logic [7:0]                    text_byte,
	input  logic                          is_end,
	output logic                          token_valid,
	input  logic                          token_ready,
	output logic [tsu_pkg::KIND_BITS-1:0] token_kind,
	output logic [OFFSET_BITS-1:0]        start_offset,
	output logic [tsu_pkg::LEN_BITS-1:0]  token_length,
	output logic [POSITION_BITS-1:0]      start_line,
	output logic [POSITION_BITS-1:0]      start_column,
	output logic                          last_of_run
);

	localparam int LB = tsu_pkg::LEN_BITS;
	localparam int PB = tsu_pkg::PREFIX_BITS;
	localparam int QD = tsu_pkg::QDEPTH;
	localparam int QA = $clog2(QD);
	localparam int QC = $clog2(QD + 1);

	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	// scan state
	tsu_pkg::mode_t             mode_q, mode_d;
	logic [OFFSET_BITS-1:0]     off_q, off_d;
	logic [POSITION_BITS-1:0]   line_q, line_d, col_q, col_d;
	logic [OFFSET_BITS-1:0]     p_off_q, p_off_d;
	logic [POSITION_BITS-1:0]   p_line_q, p_line_d, p_col_q, p_col_d;
	logic [LB-1:0]              p_len_q, p_len_d;
	logic [PB-1:0]              kw_q, kw_d;

	// output queue
	tsu_pkg::kind_t             q_kind_q [QD];
	logic [OFFSET_BITS-1:0]     q_off_q  [QD];
	logic [LB-1:0]              q_len_q  [QD];
	logic [POSITION_BITS-1:0]   q_line_q [QD];
	logic [POSITION_BITS-1:0]   q_col_q  [QD];
	logic                       q_last_q [QD];
	logic [QA-1:0]              wr_ptr_q, rd_ptr_q;
	logic [QC-1:0]              count_q;

	// up to two results per byte
	tsu_pkg::kind_t             r_kind [2];
	logic [OFFSET_BITS-1:0]     r_off  [2];
	logic [LB-1:0]              r_len  [2];
	logic [POSITION_BITS-1:0]   r_line [2];
	logic [POSITION_BITS-1:0]   r_col  [2];
	logic [1:0]                 n_res;

	logic                       accept, pop, at_end, flushed, consumed;
	logic [tsu_pkg::KIND_BITS:0] pk;
	logic [OFFSET_BITS-1:0]     off_inc;
	logic [POSITION_BITS-1:0]   col_inc, line_inc;
	logic [LB-1:0]              len_inc;

	assign text_ready = (count_q <= QC'(QD - 2));
	assign accept     = text_valid & text_ready;
	assign pop        = token_valid & token_ready;

	assign at_end   = is_end | (text_byte == tsu_pkg::CH_NUL);
	assign pk       = tsu_pkg::punct_kind(text_byte);
	assign off_inc  = (off_q == '1) ? off_q : off_q + OFFSET_BITS'(1);
	assign col_inc  = (col_q == '1) ? col_q : col_q + POS_ONE;
	assign line_inc = (line_q == '1) ? line_q : line_q + POS_ONE;
	assign len_inc  = (p_len_q == '1) ? p_len_q : p_len_q + LB'(1);

	always_comb begin
		mode_d   = mode_q;
		off_d    = off_q;
		line_d   = line_q;
		col_d    = col_q;
		p_off_d  = p_off_q;
		p_line_d = p_line_q;
		p_col_d  = p_col_q;
		p_len_d  = p_len_q;
		kw_d     = kw_q;
		flushed  = 1'b0;
		consumed = 1'b0;
		for (int i = 0; i < 2; i++) begin
			r_kind[i] = tsu_pkg::K_EOF;
			r_off[i]  = off_q;
			r_len[i]  = '0;
			r_line[i] = line_q;
			r_col[i]  = col_q;
		end
		// pending token first: either extend it or flush it into slot 0
		r_off[0]  = p_off_q;
		r_line[0] = p_line_q;
		r_col[0]  = p_col_q;
		r_len[0]  = p_len_q;
		case (mode_q)
			tsu_pkg::MODE_COLON: begin
				flushed = 1'b1;
				mode_d  = tsu_pkg::MODE_IDLE;
				if (!at_end && text_byte == tsu_pkg::CH_EQUAL) begin
					r_kind[0] = tsu_pkg::K_ASSIGN;
					r_len[0]  = LB'(2);
					consumed  = 1'b1;
					off_d     = off_inc;
					col_d     = col_inc;
				end else begin
					r_kind[0] = tsu_pkg::K_COLON;
				end
			end
			tsu_pkg::MODE_DIGITS: begin
				if (!at_end && tsu_pkg::is_digit(text_byte)) begin
					consumed = 1'b1;
					p_len_d  = len_inc;
					off_d    = off_inc;
					col_d    = col_inc;
				end else begin
					flushed   = 1'b1;
					mode_d    = tsu_pkg::MODE_IDLE;
					r_kind[0] = tsu_pkg::K_INT;
				end
			end
			tsu_pkg::MODE_WORD: begin
				if (!at_end && (tsu_pkg::is_word_start(text_byte)
						|| tsu_pkg::is_digit(text_byte))) begin
					consumed = 1'b1;
					if (p_len_q < LB'(5)) kw_d = {kw_q[PB-9:0], text_byte};
					p_len_d = len_inc;
					off_d   = off_inc;
					col_d   = col_inc;
				end else begin
					flushed   = 1'b1;
					mode_d    = tsu_pkg::MODE_IDLE;
					r_kind[0] = tsu_pkg::word_kind(p_len_q, kw_q);
				end
			end
			default: ;
		endcase

		n_res = {1'b0, flushed};
		if (!consumed) begin
			// the byte itself, emitted into the next free slot
			r_off[flushed]  = off_q;
			r_line[flushed] = line_q;
			r_col[flushed]  = col_q;
			r_len[flushed]  = LB'(1);
			if (at_end) begin
				r_kind[flushed] = tsu_pkg::K_EOF;
				r_len[flushed]  = '0;
				n_res           = n_res + 2'd1;
			end else if (tsu_pkg::is_space(text_byte)) begin
				off_d = off_inc;
				if (text_byte == tsu_pkg::CH_NEWLINE) begin
					line_d = line_inc;
					col_d  = POS_ONE;
				end else begin
					col_d = col_inc;
				end
			end else begin
				off_d = off_inc;
				col_d = col_inc;
				if (pk[tsu_pkg::KIND_BITS]) begin
					r_kind[flushed] = pk[tsu_pkg::KIND_BITS-1:0];
					n_res           = n_res + 2'd1;
				end else if (text_byte == tsu_pkg::CH_COLON
						|| tsu_pkg::is_digit(text_byte)
						|| tsu_pkg::is_word_start(text_byte)) begin
					p_off_d  = off_q;
					p_line_d = line_q;
					p_col_d  = col_q;
					p_len_d  = LB'(1);
					if (text_byte == tsu_pkg::CH_COLON) begin
						mode_d = tsu_pkg::MODE_COLON;
					end else if (tsu_pkg::is_digit(text_byte)) begin
						mode_d = tsu_pkg::MODE_DIGITS;
					end else begin
						mode_d = tsu_pkg::MODE_WORD;
						kw_d   = PB'(text_byte);
					end
				end else begin
					r_kind[flushed] = tsu_pkg::K_ERROR;
					n_res           = n_res + 2'd1;
				end
			end
		end
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tsu_pkg::MODE_IDLE;
			off_q    <= '0;
			line_q   <= POS_ONE;
			col_q    <= POS_ONE;
			p_off_q  <= '0;
			p_line_q <= POS_ONE;
			p_col_q  <= POS_ONE;
			p_len_q  <= '0;
			kw_q     <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			off_q    <= off_d;
			line_q   <= line_d;
			col_q    <= col_d;
			p_off_q  <= p_off_d;
			p_line_q <= p_line_d;
			p_col_q  <= p_col_d;
			p_len_q  <= p_len_d;
			kw_q     <= kw_d;
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 2; i++) begin
				if (2'(i) < n_res) begin
					q_kind_q[wr_ptr_q + QA'(i)] <= r_kind[i];
					q_off_q[wr_ptr_q + QA'(i)]  <= r_off[i];
					q_len_q[wr_ptr_q + QA'(i)]  <= r_len[i];
					q_line_q[wr_ptr_q + QA'(i)] <= r_line[i];
					q_col_q[wr_ptr_q + QA'(i)]  <= r_col[i];
					q_last_q[wr_ptr_q + QA'(i)] <= (2'(i + 1) == n_res);
				end
			end
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + QA'(n_res);
			if (pop) rd_ptr_q <= rd_ptr_q + QA'(1);
			count_q <= count_q + (accept ? QC'(n_res) : QC'(0)) - QC'(pop);
		end
	end

	assign token_valid  = (count_q != '0);
	assign token_kind   = q_kind_q[rd_ptr_q];
	assign start_offset = q_off_q[rd_ptr_q];
	assign token_length = q_len_q[rd_ptr_q];
	assign start_line   = q_line_q[rd_ptr_q];
	assign start_column = q_col_q[rd_ptr_q];
	assign last_of_run  = q_last_q[rd_ptr_q];

endmodule

// ===== src/tsu_checker.sv =====
// -----------------------------------------------------------------------------
// tsu_checker: port-level checks for token_scanner_unit
// Watches the token channel and text_ready over time; bound to the top level below.
// -----------------------------------------------------------------------------
module tsu_checker #(
	parameter int OFFSET_BITS   = tsu_pkg::OFFSET_BITS_DEF,
	parameter int POSITION_BITS = tsu_pkg::POSITION_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          text_ready,
	input logic                          token_valid,
	input logic                          token_ready,
	input logic [tsu_pkg::KIND_BITS-1:0] token_kind,
	input logic [OFFSET_BITS-1:0]        start_offset,
	input logic [tsu_pkg::LEN_BITS-1:0]  token_length,
	input logic [POSITION_BITS-1:0]      start_line,
	input logic [POSITION_BITS-1:0]      start_column,
	input logic                          last_of_run
);

	localparam logic [tsu_pkg::LEN_BITS-1:0] LEN_ONE = 1;

	// stalled token holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token_kind)
		&& $stable(start_offset) && $stable(token_length) && $stable(last_of_run))
		else $error("token changed while stalled");

	// EOF closes the run and is empty
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == tsu_pkg::K_EOF |-> token_length == '0 && last_of_run)
		else $error("bad EOF token");

	// single-byte tokens and errors are one long
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind == tsu_pkg::K_ERROR || (token_kind <= tsu_pkg::K_RBRACE
		&& token_kind != tsu_pkg::K_ASSIGN)) |-> token_length == LEN_ONE)
		else $error("single-byte token with wrong length");

	// positions count from one; no unknown kinds
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> start_line != '0 && start_column != '0
		&& token_kind <= tsu_pkg::K_ERROR)
		else $error("bad token position or kind");

	// an empty output queue always has room for a byte
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!token_valid |-> text_ready)
		else $error("input blocked with empty queue");

endmodule

bind token_scanner_unit tsu_checker #(
	.OFFSET_BITS(OFFSET_BITS),
	.POSITION_BITS(POSITION_BITS)
) u_tsu_checker (.*);
